// ===== rtl/pv2_pkg.sv =====
// ----------------------------------------------------------------------------
// pv2_pkg
// Shared types, codes and constants of the PROXY v2 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pv2_pkg;

	localparam int SigLen = 12;
	localparam logic [16:0] FIXED_LEN = 17'd16;
	localparam logic [15:0] V4_BLOCK = 16'd12;
	localparam logic [15:0] V6_BLOCK = 16'd36;
	localparam logic [7:0] VER_MASK = 8'hF0;
	localparam logic [7:0] VER_V2 = 8'h20;
	localparam logic [7:0] CMD_MASK = 8'h0F;

	localparam logic [3:0] CMD_LOCAL = 4'd0;
	localparam logic [3:0] CMD_PROXY = 4'd1;
	localparam logic [3:0] FAM_INET = 4'd1;
	localparam logic [3:0] FAM_INET6 = 4'd2;

	localparam logic [2:0] ST_PROXY_OK = 3'd0;
	localparam logic [2:0] ST_LOCAL = 3'd1;
	localparam logic [2:0] ST_BAD_SIG = 3'd2;
	localparam logic [2:0] ST_BAD_VER = 3'd3;
	localparam logic [2:0] ST_BAD_CMD = 3'd4;
	localparam logic [2:0] ST_SHORT = 3'd5;

	localparam logic [1:0] AK_IPV4 = 2'd0;
	localparam logic [1:0] AK_IPV6 = 2'd1;
	localparam logic [1:0] AK_NONE = 2'd2;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  address_kind;
		logic [63:0] source_addr_high;
		logic [63:0] source_addr_low;
		logic [15:0] source_port;
		logic [16:0] header_length;
	} verdict_t;

	typedef struct packed {
		logic     valid;
		verdict_t verdict;
	} verdict_beat_t;

	function automatic logic [7:0] sig_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h0D;
			4'd1: b = 8'h0A;
			4'd2: b = 8'h0D;
			4'd3: b = 8'h0A;
			4'd4: b = 8'h00;
			4'd5: b = 8'h0D;
			4'd6: b = 8'h0A;
			4'd7: b = 8'h51;
			4'd8: b = 8'h55;
			4'd9: b = 8'h49;
			4'd10: b = 8'h54;
			4'd11: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pv2_byte_if.sv =====
// ----------------------------------------------------------------------------
// pv2_byte_if
// Byte channel into the parser: one connection byte and a restart mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface pv2_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       restart;

	modport source (output valid, output data_byte, output restart, input ready);
	modport sink (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/pv2_verdict_if.sv =====
// ----------------------------------------------------------------------------
// pv2_verdict_if
// Verdict channel out of the parser: one beat per completed header.
// ----------------------------------------------------------------------------
`default_nettype none

interface pv2_verdict_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  address_kind;
	logic [63:0] source_addr_high;
	logic [63:0] source_addr_low;
	logic [15:0] source_port;
	logic [16:0] header_length;

	modport source (output valid, output status, output address_kind,
		output source_addr_high, output source_addr_low, output source_port,
		output header_length, input ready);
	modport sink (input valid, input status, input address_kind,
		input source_addr_high, input source_addr_low, input source_port,
		input header_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/proxy_v2_header_parser.sv =====
// ----------------------------------------------------------------------------
// proxy_v2_header_parser
// PROXY protocol v2 header parser, one connection byte per beat.
// ----------------------------------------------------------------------------
// ingress carries one byte per beat; restart marks the first header byte of a
// new connection and drops any header in progress. egress carries one verdict
// per header: status, address kind, source address and port, header length.
// Bytes outside a header (after a verdict, before a restart) are taken and
// dropped.
// Throughput: one byte per clock while ingress.ready is high. The verdict
// beat for the byte that completes the header (byte 15, or the last payload
// byte) is held in the output register, or in the skid stage behind it.
// A stalled egress keeps its beat; one more verdict fits in the skid stage,
// and only then does ingress.ready fall. Since a header spans at least 16
// bytes, ready falls only if egress stalls through a whole further header.
// Reset: no header in progress, egress empty, ingress ready.
// ----------------------------------------------------------------------------
`default_nettype none

module proxy_v2_header_parser import pv2_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pv2_byte_if.sink   ingress,
	pv2_verdict_if.source egress
);

	logic          beat;
	logic          can_take;
	verdict_beat_t dec_result;
	verdict_t      out_data;

	assign ingress.ready = can_take;
	assign beat = ingress.valid && can_take;

	pv2_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.data_byte (ingress.data_byte),
		.restart   (ingress.restart),
		.result    (dec_result)
	);

	pv2_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (dec_result),
		.can_take  (can_take),
		.out_valid (egress.valid),
		.out_ready (egress.ready),
		.out_data  (out_data)
	);

	assign egress.status = out_data.status;
	assign egress.address_kind = out_data.address_kind;
	assign egress.source_addr_high = out_data.source_addr_high;
	assign egress.source_addr_low = out_data.source_addr_low;
	assign egress.source_port = out_data.source_port;
	assign egress.header_length = out_data.header_length;

endmodule

`default_nettype wire

// ===== rtl/pv2_core.sv =====
// ----------------------------------------------------------------------------
// pv2_core
// Header state and per-byte decode; raises a verdict beat when a header ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pv2_core import pv2_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          beat,
	input  wire logic [7:0]    data_byte,
	input  wire logic          restart,
	output verdict_beat_t      result
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	logic [1:0]  phase_q, r_phase, n_phase;
	logic [16:0] pos_q, r_pos, n_pos;
	logic        mis_q, r_mis, n_mis;
	logic [7:0]  vc_q, r_vc, n_vc;
	logic [3:0]  fam_q, r_fam, n_fam;
	logic [15:0] dl_q, r_dl, n_dl;
	logic [63:0] hi_q, r_hi, n_hi;
	logic [63:0] lo_q, r_lo, n_lo;
	logic [15:0] port_q, r_port, n_port;
	logic [1:0]  kind;
	logic [3:0]  cmd;

	function automatic logic [1:0] kind_of(input logic [7:0] vc, input logic [3:0] fam);
		logic [1:0] k;
		k = AK_NONE;
		if ((vc & CMD_MASK) == {4'd0, CMD_PROXY}) begin
			if (fam == FAM_INET)
				k = AK_IPV4;
			else if (fam == FAM_INET6)
				k = AK_IPV6;
		end
		return k;
	endfunction

	function automatic verdict_t make_final(input logic [1:0] k, input logic [63:0] hi,
			input logic [63:0] lo, input logic [15:0] port, input logic [15:0] dl);
		verdict_t v;
		v.header_length = FIXED_LEN + {1'b0, dl};
		case (k)
			AK_IPV4: begin
				v.status = ST_PROXY_OK;
				v.address_kind = AK_IPV4;
				v.source_addr_high = 64'd0;
				v.source_addr_low = {32'd0, lo[31:0]};
				v.source_port = port;
			end
			AK_IPV6: begin
				v.status = ST_PROXY_OK;
				v.address_kind = AK_IPV6;
				v.source_addr_high = hi;
				v.source_addr_low = lo;
				v.source_port = port;
			end
			default: begin
				v.status = ST_LOCAL;
				v.address_kind = AK_NONE;
				v.source_addr_high = 64'd0;
				v.source_addr_low = 64'd0;
				v.source_port = 16'd0;
			end
		endcase
		return v;
	endfunction

	function automatic verdict_t make_error(input logic [2:0] st);
		verdict_t v;
		v.status = st;
		v.address_kind = AK_NONE;
		v.source_addr_high = 64'd0;
		v.source_addr_low = 64'd0;
		v.source_port = 16'd0;
		v.header_length = FIXED_LEN;
		return v;
	endfunction

	always_comb begin
		r_phase = restart ? PH_HEADER : phase_q;
		r_pos = restart ? 17'd0 : pos_q;
		r_mis = restart ? 1'b0 : mis_q;
		r_vc = restart ? 8'd0 : vc_q;
		r_fam = restart ? 4'd0 : fam_q;
		r_dl = restart ? 16'd0 : dl_q;
		r_hi = restart ? 64'd0 : hi_q;
		r_lo = restart ? 64'd0 : lo_q;
		r_port = restart ? 16'd0 : port_q;

		n_phase = phase_q;
		n_pos = pos_q;
		n_mis = mis_q;
		n_vc = vc_q;
		n_fam = fam_q;
		n_dl = dl_q;
		n_hi = hi_q;
		n_lo = lo_q;
		n_port = port_q;
		result.valid = 1'b0;
		result.verdict = make_error(ST_PROXY_OK);
		kind = AK_NONE;
		cmd = 4'd0;

		if (beat) begin
			n_phase = r_phase;
			n_pos = r_pos;
			n_mis = r_mis;
			n_vc = r_vc;
			n_fam = r_fam;
			n_dl = r_dl;
			n_hi = r_hi;
			n_lo = r_lo;
			n_port = r_port;
			if (r_phase == PH_HEADER) begin
				n_pos = r_pos + 17'd1;
				if (r_pos < 17'd12) begin
					if (data_byte != sig_byte(r_pos[3:0]))
						n_mis = 1'b1;
				end else if (r_pos == 17'd12) begin
					n_vc = data_byte;
				end else if (r_pos == 17'd13) begin
					n_fam = data_byte[7:4];
				end else if (r_pos == 17'd14) begin
					n_dl = {data_byte, 8'd0};
				end else begin
					n_dl = {r_dl[15:8], data_byte};
					kind = kind_of(r_vc, r_fam);
					cmd = r_vc[3:0];
					n_phase = PH_IDLE;
					result.valid = 1'b1;
					if (r_mis) begin
						result.verdict = make_error(ST_BAD_SIG);
					end else if ((r_vc & VER_MASK) != VER_V2) begin
						result.verdict = make_error(ST_BAD_VER);
					end else if (cmd != CMD_LOCAL && cmd != CMD_PROXY) begin
						result.verdict = make_error(ST_BAD_CMD);
					end else if ((kind == AK_IPV4 && n_dl < V4_BLOCK) ||
							(kind == AK_IPV6 && n_dl < V6_BLOCK)) begin
						result.verdict = make_error(ST_SHORT);
					end else if (n_dl == 16'd0) begin
						result.verdict = make_final(kind, r_hi, r_lo, r_port, n_dl);
					end else begin
						result.valid = 1'b0;
						n_phase = PH_PAYLOAD;
					end
				end
			end else if (r_phase == PH_PAYLOAD) begin
				n_pos = r_pos + 17'd1;
				kind = kind_of(r_vc, r_fam);
				if (kind == AK_IPV4) begin
					if (r_pos < 17'd20)
						n_lo = {r_lo[55:0], data_byte};
					else if (r_pos == 17'd24 || r_pos == 17'd25)
						n_port = {r_port[7:0], data_byte};
				end else if (kind == AK_IPV6) begin
					if (r_pos < 17'd24)
						n_hi = {r_hi[55:0], data_byte};
					else if (r_pos < 17'd32)
						n_lo = {r_lo[55:0], data_byte};
					else if (r_pos == 17'd48 || r_pos == 17'd49)
						n_port = {r_port[7:0], data_byte};
				end
				if (n_pos == FIXED_LEN + {1'b0, r_dl}) begin
					n_phase = PH_IDLE;
					result.valid = 1'b1;
					result.verdict = make_final(kind, n_hi, n_lo, n_port, r_dl);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= 17'd0;
			mis_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			pos_q <= n_pos;
			mis_q <= n_mis;
		end
	end

	always_ff @(posedge clk) begin
		vc_q <= n_vc;
		fam_q <= n_fam;
		dl_q <= n_dl;
		hi_q <= n_hi;
		lo_q <= n_lo;
		port_q <= n_port;
	end

endmodule

`default_nettype wire

// ===== rtl/pv2_outbuf.sv =====
// ----------------------------------------------------------------------------
// pv2_outbuf
// Output register with a skid stage between the decoder and the verdict port.
// ----------------------------------------------------------------------------
`default_nettype none

module pv2_outbuf import pv2_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  verdict_beat_t      push,
	output logic               can_take,
	output logic               out_valid,
	input  wire logic          out_ready,
	output verdict_t           out_data
);

	logic     out_valid_q;
	logic     skid_valid_q;
	verdict_t out_q;
	verdict_t skid_q;
	logic     pop;

	assign pop = out_valid_q && out_ready;
	assign can_take = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push.valid;
			end
		end else if (push.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (push.valid)
				out_q <= push.verdict;
		end else if (push.valid) begin
			skid_q <= push.verdict;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pv2_checker.sv =====
// ----------------------------------------------------------------------------
// pv2_checker
// Port-level checks on the verdict channel of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

module pv2_checker import pv2_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [1:0]  address_kind,
	input wire logic [63:0] source_addr_high,
	input wire logic [63:0] source_addr_low,
	input wire logic [15:0] source_port,
	input wire logic [16:0] header_length
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(header_length) && $stable(source_addr_low))
		else $error("verdict beat changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SHORT)
		else $error("status code out of range");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PROXY_OK && status != ST_LOCAL |->
		address_kind == AK_NONE && source_addr_high == 64'd0 &&
		source_addr_low == 64'd0 && source_port == 16'd0 && header_length == FIXED_LEN)
		else $error("error verdict carries address or length");

	a_local_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_LOCAL |-> address_kind == AK_NONE &&
		source_port == 16'd0 && source_addr_low == 64'd0)
		else $error("local verdict carries an address");

	a_proxy_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_PROXY_OK |-> address_kind != AK_NONE &&
		header_length >= FIXED_LEN + {1'b0, V4_BLOCK} &&
		(address_kind != AK_IPV4 || source_addr_high == 64'd0))
		else $error("proxy verdict with bad kind or length");

endmodule

bind proxy_v2_header_parser pv2_checker u_pv2_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (egress.valid),
	.out_ready        (egress.ready),
	.status           (egress.status),
	.address_kind     (egress.address_kind),
	.source_addr_high (egress.source_addr_high),
	.source_addr_low  (egress.source_addr_low),
	.source_port      (egress.source_port),
	.header_length    (egress.header_length)
);

`default_nettype wire
